>>> rtl/core/arp_pkg.sv
package arp_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;

  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_ADDR_BITS = 3;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_FRAME_WIDTH    = 3'd0,
    REG_FRAME_HEIGHT   = 3'd1,
    REG_RING_RADIUS    = 3'd2,
    REG_RING_THICKNESS = 3'd3,
    REG_PIXEL_ASPECT   = 3'd4
  } cfg_reg_t;

  // sum of squares in Q.24, then scaled for the fraction bits
  localparam int SUM_BITS  = ((2 * COORD_BITS + 24) > 48 ? (2 * COORD_BITS + 24) : 48) + 1;
  localparam int SQ_SHIFT  = (FRAC_BITS >= 12) ? (2 * FRAC_BITS - 24) : 0;
  localparam int OUT_SHIFT = (FRAC_BITS >= 12) ? 0 : (12 - FRAC_BITS);
  localparam int RAD_BITS  = SUM_BITS + SQ_SHIFT;
  localparam int ROOT_BITS = (RAD_BITS + 1) / 2;
  localparam int DIST_BITS = ROOT_BITS - OUT_SHIFT;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [7:0]            old_value;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] new_value;
    logic       in_ring;
  } pixel_out_t;

endpackage

>>> rtl/core/antialiased_ring_pixel.sv
// Channel   Ports                         Handshake
// pixel     start, busy, pixel            beat taken when start & !busy
// result    done, result                  beat valid for one cycle on done
// config    cfg_we, cfg_addr, cfg_data    write when cfg_we
//
// One pixel per clock; busy is always low. The square root pipeline resolves
// one root bit per stage.
// rst clears the valid bits and loads the register defaults.
// The receiver cannot stall; results leave on done in input order.
module antialiased_ring_pixel (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  arp_pkg::pixel_in_t               pixel,
  output logic                             done,
  output arp_pkg::pixel_out_t              result,
  input  logic                             cfg_we,
  input  logic [arp_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [arp_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import arp_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int RW = RAD_BITS + 1;
  localparam int MW = FRAC_BITS + 1;
  localparam int DW = (DIST_BITS > 11 + FRAC_BITS ? DIST_BITS : 11 + FRAC_BITS) + 1;

  typedef struct packed {
    logic [7:0] old_value;
    logic       twice;
    logic       in_scan;
  } meta_t;

  logic [CB-1:0] frame_width;
  logic [CB-1:0] frame_height;
  logic [10:0]   ring_radius;
  logic [7:0]    ring_thickness;
  logic [15:0]   pixel_aspect;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= CB'(1920);
      frame_height   <= CB'(1080);
      ring_radius    <= 11'd486;
      ring_thickness <= 8'd10;
      pixel_aspect   <= 16'd4096;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_FRAME_WIDTH:    frame_width    <= cfg_data[CB-1:0];
        REG_FRAME_HEIGHT:   frame_height   <= cfg_data[CB-1:0];
        REG_RING_RADIUS:    ring_radius    <= cfg_data[10:0];
        REG_RING_THICKNESS: ring_thickness <= cfg_data[7:0];
        REG_PIXEL_ASPECT:   pixel_aspect   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  function automatic logic [7:0] blend(input logic [7:0] old, input logic [MW-1:0] m);
    logic [MW+8:0] acc;
    logic [MW-1:0] one;
    one = MW'(1) << FRAC_BITS;
    acc = (MW+9)'(m) * (MW+9)'(8'hff) + (MW+9)'(old) * (MW+9)'(one - m);
    return acc[FRAC_BITS+7:FRAC_BITS];
  endfunction

  logic [CB-1:0] xc, yc;
  logic [11:0]   rmax;
  assign xc   = frame_width >> 1;
  assign yc   = frame_height >> 1;
  assign rmax = 12'(ring_radius) + 12'(ring_thickness);

  // stage 1: offsets from the centre
  logic          s1_vld;
  logic [CB-1:0] s1_a, s1_b;
  logic [7:0]    s1_old;
  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else     s1_vld <= start;
    s1_a   <= (pixel.pixel_y >= yc) ? pixel.pixel_y - yc : yc - pixel.pixel_y;
    s1_b   <= (pixel.pixel_x >= xc) ? pixel.pixel_x - xc : xc - pixel.pixel_x;
    s1_old <= pixel.old_value;
  end

  // stage 2: a*a, b*sar, scan bounds
  logic             s2_vld;
  logic [2*CB-1:0]  s2_aa;
  logic [23:0]      s2_bs;
  meta_t            s2_meta;
  logic [CB+15:0]   bs_full;
  assign bs_full = (CB+16)'(s1_b) * (CB+16)'(pixel_aspect);
  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else     s2_vld <= s1_vld;
    s2_aa             <= (2*CB)'(s1_a) * (2*CB)'(s1_a);
    s2_bs             <= bs_full[23:0];
    s2_meta.old_value <= s1_old;
    s2_meta.twice     <= (s1_a == '0) || (s1_b == '0);
    s2_meta.in_scan   <= ((CB+12)'(s1_a) <= (CB+12)'(rmax)) &&
                         ((CB+28)'(bs_full) <= ((CB+28)'(rmax) << 12));
  end

  // stage 3: sum of squares
  logic  s3_vld;
  logic [RW-1:0] s3_sum;
  meta_t s3_meta;
  logic [SUM_BITS-1:0] sum;
  assign sum = (SUM_BITS'(s2_aa) << 24) + SUM_BITS'(48'(s2_bs) * 48'(s2_bs));
  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else     s3_vld <= s2_vld;
    s3_sum  <= RW'(sum) << SQ_SHIFT;
    s3_meta <= s2_meta;
  end

  // square root, one root bit per stage
  logic [RW-1:0]        sq_rem  [0:ROOT_BITS];
  logic [ROOT_BITS-1:0] sq_root [0:ROOT_BITS];
  logic                 sq_vld  [0:ROOT_BITS];
  meta_t                sq_meta [0:ROOT_BITS];

  assign sq_rem[0]  = s3_sum;
  assign sq_root[0] = '0;
  assign sq_vld[0]  = s3_vld;
  assign sq_meta[0] = s3_meta;

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
    localparam int BIT = ROOT_BITS - 1 - k;
    logic [RW-1:0] trial;
    assign trial = (RW'(sq_root[k]) << (BIT + 1)) | (RW'(1) << (2 * BIT));
    always_ff @(posedge clk) begin
      if (rst) sq_vld[k+1] <= 1'b0;
      else     sq_vld[k+1] <= sq_vld[k];
      if (sq_rem[k] >= trial) begin
        sq_rem[k+1]  <= sq_rem[k] - trial;
        sq_root[k+1] <= sq_root[k] | (ROOT_BITS'(1) << BIT);
      end else begin
        sq_rem[k+1]  <= sq_rem[k];
        sq_root[k+1] <= sq_root[k];
      end
      sq_meta[k+1] <= sq_meta[k];
    end
  end

  // band test and mix
  logic [DW-1:0] cf, rf, lf, df, one_d, tail;
  logic [MW-1:0] mix;
  logic          band;
  assign cf    = DW'(sq_root[ROOT_BITS] >> OUT_SHIFT);
  assign rf    = DW'(ring_radius) << FRAC_BITS;
  assign lf    = (DW'(ring_thickness) + DW'(1)) << FRAC_BITS;
  assign one_d = DW'(1) << FRAC_BITS;
  assign df    = cf - rf;
  assign tail  = lf - df;
  assign band  = sq_meta[ROOT_BITS].in_scan && (cf > rf) && (df < lf);
  always_comb begin
    if (df < one_d)        mix = MW'(df);
    else if (tail < one_d) mix = MW'(tail);
    else                   mix = MW'(one_d);
  end

  logic          p_vld, p_hit;
  logic [MW-1:0] p_mix;
  meta_t         p_meta;
  always_ff @(posedge clk) begin
    if (rst) p_vld <= 1'b0;
    else     p_vld <= sq_vld[ROOT_BITS];
    p_hit  <= band;
    p_mix  <= mix;
    p_meta <= sq_meta[ROOT_BITS];
  end

  // first blend
  logic          b1_vld, b1_hit, b1_twice;
  logic [MW-1:0] b1_mix;
  logic [7:0]    b1_val;
  always_ff @(posedge clk) begin
    if (rst) b1_vld <= 1'b0;
    else     b1_vld <= p_vld;
    b1_hit   <= p_hit;
    b1_twice <= p_meta.twice;
    b1_mix   <= p_mix;
    if (!p_hit)                          b1_val <= p_meta.old_value;
    else if (p_mix[FRAC_BITS])           b1_val <= 8'hff;
    else                                 b1_val <= blend(p_meta.old_value, p_mix);
  end

  // second blend for pixels on one axis, output register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= b1_vld;
    result.in_ring <= b1_hit;
    if (!b1_hit || !b1_twice)    result.new_value <= b1_val;
    else if (b1_mix[FRAC_BITS])  result.new_value <= 8'hff;
    else                         result.new_value <= blend(b1_val, b1_mix);
  end

endmodule
